@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define AALR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define AALR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/aalr_pkg.sv @@
package aalr_pkg;

	// Coordinate and fixed-point geometry
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int Y_BITS     = COORD_BITS + FRAC_BITS;
	localparam int QUO_BITS   = FRAC_BITS + 1;
	localparam int SLOPE_BITS = FRAC_BITS + 2;
	localparam int CNT_BITS   = $clog2(FRAC_BITS + 1);

	// Output and register widths
	localparam int PITCH_BITS = 13;
	localparam int COLOR_BITS = 24;
	localparam int ADDR_BITS  = 24;
	localparam int COV_BITS   = 8;
	localparam int VALUE_BITS = COV_BITS + COLOR_BITS;

	// Fixed-point 1.0 in the y and slope formats
	localparam logic [Y_BITS-1:0]     Y_ONE     = Y_BITS'(1) << FRAC_BITS;
	localparam logic [SLOPE_BITS-1:0] SLOPE_ONE = SLOPE_BITS'(1) << FRAC_BITS;

	// Register reset values
	localparam logic [PITCH_BITS-1:0] ROW_PITCH_RST  = PITCH_BITS'(1024);
	localparam logic [COLOR_BITS-1:0] BASE_COLOR_RST = COLOR_BITS'(24'h808080);

	// Command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	// Configuration register indexes
	typedef enum logic [0:0] {
		CFG_ROW_PITCH  = 1'b0,
		CFG_BASE_COLOR = 1'b1
	} cfg_idx_t;

endpackage

@@ rtl/antialiased_line_rasterizer_top.sv @@
// Wu-style antialiased line rasterizer. A load command (cmd 0) takes two
// endpoints and accepts no further item until the slope is set: S_SWAP and
// S_ORDER pick the major axis and order the ends, then S_DIV starts a
// restoring divider that forms the Q1.16 slope one quotient bit per cycle. A
// step command (cmd 1) on an active line waits while the output is stalled
// and gives two output beats: the pixel at floor(y) with coverage 255 minus
// the fraction, then floor(y)-1 with the fraction; line_done marks the
// second beat of the last column or of one after which y would drop below
// one. A step with no active line, or one stopped by the end or y-below-one
// guard, gives no beat and leaves the block idle. The output register holds
// one beat, so a new item is accepted while the last beat still waits
// downstream. Write row_pitch and base_color only while the block is idle.
module antialiased_line_rasterizer_top (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [0:0]                       cfg_index,
	input  logic [aalr_pkg::COLOR_BITS-1:0]  cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             cmd,
	input  logic [aalr_pkg::COORD_BITS-1:0]  start_x,
	input  logic [aalr_pkg::COORD_BITS-1:0]  start_y,
	input  logic [aalr_pkg::COORD_BITS-1:0]  end_x,
	input  logic [aalr_pkg::COORD_BITS-1:0]  end_y,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [aalr_pkg::COORD_BITS-1:0]  pixel_x,
	output logic [aalr_pkg::COORD_BITS-1:0]  pixel_y,
	output logic [aalr_pkg::ADDR_BITS-1:0]   pixel_addr,
	output logic [aalr_pkg::COV_BITS-1:0]    coverage,
	output logic [aalr_pkg::VALUE_BITS-1:0]  pixel_value,
	output logic                             line_done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWAP,
		S_ORDER,
		S_DIV,
		S_PIX0,
		S_PIX1
	} state_t;

	function automatic logic [aalr_pkg::COORD_BITS-1:0] abs_diff(
		input logic [aalr_pkg::COORD_BITS-1:0] a,
		input logic [aalr_pkg::COORD_BITS-1:0] b
	);
		logic [aalr_pkg::COORD_BITS:0] d;
		logic [aalr_pkg::COORD_BITS:0] nd;
		d  = {1'b0, a} - {1'b0, b};
		nd = -d;
		return d[aalr_pkg::COORD_BITS] ? nd[aalr_pkg::COORD_BITS-1:0]
		                               : d[aalr_pkg::COORD_BITS-1:0];
	endfunction

	state_t                            state_q;
	logic [aalr_pkg::PITCH_BITS-1:0]   row_pitch_q;
	logic [aalr_pkg::COLOR_BITS-1:0]   base_color_q;
	logic                              active_q;
	logic                              steep_q;
	logic [aalr_pkg::COORD_BITS-1:0]   column_q;
	logic [aalr_pkg::COORD_BITS-1:0]   column_end_q;
	logic [aalr_pkg::Y_BITS-1:0]       y_q;
	logic signed [aalr_pkg::SLOPE_BITS-1:0] slope_q;
	logic                              div_start_q;
	logic                              out_valid_q;

	// setup and output payload
	logic [aalr_pkg::COORD_BITS-1:0]   ax_q, ay_q, bx_q, by_q;
	logic [aalr_pkg::COORD_BITS-1:0]   dx_q;
	logic [aalr_pkg::COORD_BITS-1:0]   dyabs_q;
	logic                              neg_q;
	logic [aalr_pkg::COORD_BITS-1:0]   pixel_x_q, pixel_y_q;
	logic [aalr_pkg::ADDR_BITS-1:0]    pixel_addr_q;
	logic [aalr_pkg::COV_BITS-1:0]     coverage_q;
	logic                              line_done_q;

	logic                              in_acc;
	logic                              out_free;
	logic                              beat_load;
	logic                              steep;
	logic                              order_swap;
	logic [aalr_pkg::COORD_BITS-1:0]   lo_x, hi_x, lo_y, hi_y;
	logic [aalr_pkg::COORD_BITS:0]     dy_full;
	logic [aalr_pkg::COORD_BITS:0]     dy_neg;
	logic                              guard_ok;
	logic                              div_done;
	logic [aalr_pkg::QUO_BITS-1:0]     div_quo;
	logic [aalr_pkg::SLOPE_BITS-1:0]   quo_ext;
	logic [aalr_pkg::SLOPE_BITS-1:0]   slope_new;
	logic signed [aalr_pkg::Y_BITS:0]  next_y;
	logic                              next_low;
	logic                              second;
	logic [aalr_pkg::COORD_BITS-1:0]   yi;
	logic [aalr_pkg::COV_BITS-1:0]     fr;
	logic [aalr_pkg::COORD_BITS-1:0]   minor;
	logic [aalr_pkg::COORD_BITS-1:0]   px, py;
	logic [aalr_pkg::COV_BITS-1:0]     cov;
	logic [aalr_pkg::COORD_BITS+aalr_pkg::PITCH_BITS-1:0] row_off;
	logic [aalr_pkg::ADDR_BITS-1:0]    addr;
	logic                              done_pix;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign beat_load = ((state_q == S_PIX0) || (state_q == S_PIX1)) && out_free;

	// Steep test on the latched endpoints
	assign steep = abs_diff(by_q, ay_q) > abs_diff(bx_q, ax_q);

	// Order ends so the major coordinate rises
	assign order_swap = (ax_q > bx_q);
	assign lo_x    = order_swap ? bx_q : ax_q;
	assign hi_x    = order_swap ? ax_q : bx_q;
	assign lo_y    = order_swap ? by_q : ay_q;
	assign hi_y    = order_swap ? ay_q : by_q;
	assign dy_full = {1'b0, hi_y} - {1'b0, lo_y};
	assign dy_neg  = -dy_full;

	// Divider for the slope
	aalr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (dyabs_q),
		.den    (dx_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign quo_ext   = {1'b0, div_quo};
	assign slope_new = (dx_q == '0) ? aalr_pkg::SLOPE_ONE : (neg_q ? -quo_ext : quo_ext);

	// Column guard and next y
	assign guard_ok = (column_q <= column_end_q) && (y_q >= aalr_pkg::Y_ONE);
	assign next_y   = $signed({1'b0, y_q}) + (aalr_pkg::Y_BITS + 1)'(slope_q);
	assign next_low = next_y < $signed({1'b0, aalr_pkg::Y_ONE});

	// Pixel of the current column
	assign second   = (state_q == S_PIX1);
	assign yi       = y_q[aalr_pkg::Y_BITS-1:aalr_pkg::FRAC_BITS];
	assign fr       = y_q[aalr_pkg::FRAC_BITS-1 -: aalr_pkg::COV_BITS];
	assign minor    = second ? yi - 1'b1 : yi;
	assign cov      = second ? fr : ~fr;
	assign px       = steep_q ? minor : column_q;
	assign py       = steep_q ? column_q : minor;
	assign row_off  = py * row_pitch_q;
	assign addr     = row_off[aalr_pkg::ADDR_BITS-1:0] + aalr_pkg::ADDR_BITS'(px);
	assign done_pix = second && ((column_q == column_end_q) || next_low);

	// Sequencer, line state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			row_pitch_q  <= aalr_pkg::ROW_PITCH_RST;
			base_color_q <= aalr_pkg::BASE_COLOR_RST;
			active_q     <= 1'b0;
			steep_q      <= 1'b0;
			column_q     <= '0;
			column_end_q <= '0;
			y_q          <= '0;
			slope_q      <= '0;
			div_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			div_start_q <= (state_q == S_ORDER);
			if (cfg_we) begin
				case (aalr_pkg::cfg_idx_t'(cfg_index))
					aalr_pkg::CFG_ROW_PITCH:
						row_pitch_q <= cfg_data[aalr_pkg::PITCH_BITS-1:0];
					aalr_pkg::CFG_BASE_COLOR:
						base_color_q <= cfg_data;
					default: ;
				endcase
			end
			// Raise valid on a new beat, drop it once the beat is taken
			if (beat_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (cmd == aalr_pkg::CMD_LOAD) begin
							state_q <= S_SWAP;
						end else if (active_q) begin
							if (guard_ok)
								state_q <= S_PIX0;
							else
								active_q <= 1'b0;
						end
					end
				end
				S_SWAP: begin
					steep_q <= steep;
					state_q <= S_ORDER;
				end
				S_ORDER: begin
					column_q     <= lo_x;
					column_end_q <= hi_x;
					y_q          <= {lo_y, {aalr_pkg::FRAC_BITS{1'b0}}};
					state_q      <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						slope_q  <= $signed(slope_new);
						active_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_PIX0: begin
					if (out_free) begin
						state_q <= S_PIX1;
					end
				end
				S_PIX1: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (done_pix) begin
							active_q <= 1'b0;
						end else begin
							column_q <= column_q + 1'b1;
							y_q      <= next_y[aalr_pkg::Y_BITS-1:0];
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Latch endpoints, swap axes, hold setup values
	always_ff @(posedge clk) begin
		if (in_acc && (cmd == aalr_pkg::CMD_LOAD)) begin
			ax_q <= start_x;
			ay_q <= start_y;
			bx_q <= end_x;
			by_q <= end_y;
		end else if (state_q == S_SWAP && steep) begin
			ax_q <= ay_q;
			ay_q <= ax_q;
			bx_q <= by_q;
			by_q <= bx_q;
		end
		if (state_q == S_ORDER) begin
			dx_q    <= hi_x - lo_x;
			neg_q   <= dy_full[aalr_pkg::COORD_BITS];
			dyabs_q <= dy_full[aalr_pkg::COORD_BITS] ? dy_neg[aalr_pkg::COORD_BITS-1:0]
			                                         : dy_full[aalr_pkg::COORD_BITS-1:0];
		end
	end

	// Load the output beat
	always_ff @(posedge clk) begin
		if (beat_load) begin
			pixel_x_q    <= px;
			pixel_y_q    <= py;
			pixel_addr_q <= addr;
			coverage_q   <= cov;
			line_done_q  <= done_pix;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_addr  = pixel_addr_q;
	assign coverage    = coverage_q;
	assign pixel_value = {coverage_q, base_color_q};
	assign line_done   = line_done_q;

endmodule

@@ rtl/aalr_div.sv @@
// Restoring divider: quotient = (num << FRAC_BITS) / den, one bit per cycle.
// Expects num <= den, so the quotient fits in FRAC_BITS + 1 bits.
module aalr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [aalr_pkg::COORD_BITS-1:0]  num,
	input  logic [aalr_pkg::COORD_BITS-1:0]  den,
	output logic                             done,
	output logic [aalr_pkg::QUO_BITS-1:0]    quo
);

	logic                            busy_q;
	logic                            done_q;
	logic [aalr_pkg::CNT_BITS-1:0]   cnt_q;
	logic [aalr_pkg::COORD_BITS-1:0] rem_q;
	logic [aalr_pkg::QUO_BITS-1:0]   quo_q;

	logic [aalr_pkg::COORD_BITS:0]   trial;
	logic [aalr_pkg::COORD_BITS:0]   diff;
	logic                            ge;
	logic                            last;

	// First step compares the integer part, later steps shift in a zero
	assign trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign diff  = trial - {1'b0, den};
	assign ge    = (trial >= {1'b0, den});
	assign last  = (cnt_q == aalr_pkg::CNT_BITS'(aalr_pkg::FRAC_BITS));

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[aalr_pkg::COORD_BITS-1:0] : trial[aalr_pkg::COORD_BITS-1:0];
			quo_q <= {quo_q[aalr_pkg::QUO_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

@@ rtl/aalr_checker.sv @@
`include "assert_macros.svh"

module aalr_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             cmd,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [aalr_pkg::COORD_BITS-1:0]  pixel_x,
	input  logic [aalr_pkg::COORD_BITS-1:0]  pixel_y,
	input  logic [aalr_pkg::ADDR_BITS-1:0]   pixel_addr,
	input  logic [aalr_pkg::COV_BITS-1:0]    coverage,
	input  logic [aalr_pkg::VALUE_BITS-1:0]  pixel_value,
	input  logic                             line_done
);

	// A stalled beat holds its payload
	`AALR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_addr) && $stable(pixel_value) && $stable(line_done), "output beat changed while stalled")

	// Coverage sits in the top byte of the pixel word
	`AALR_ASSERT_SAME(a_cov_in_value, clk, arst_n, out_valid, pixel_value[aalr_pkg::VALUE_BITS-1 -: aalr_pkg::COV_BITS] == coverage, "coverage missing from pixel word")

	// A load always occupies the block for setup and divide
	`AALR_ASSERT_NEXT(a_load_busy, clk, arst_n, in_valid && !in_stall && (cmd == aalr_pkg::CMD_LOAD), in_stall, "input not stalled after a load")

endmodule

bind antialiased_line_rasterizer_top aalr_checker u_aalr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.cmd         (cmd),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_addr  (pixel_addr),
	.coverage    (coverage),
	.pixel_value (pixel_value),
	.line_done   (line_done)
);
